>>> hw/rtl/kdwf_pkg.sv
`timescale 1ns / 1ps

package kdwf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned KDWF_MAX_COLS      = 2048;
  localparam int unsigned KDWF_MAX_ROWS      = 512;
  localparam int unsigned KDWF_WINDOW_RADIUS = 2;

  // Field widths
  localparam int unsigned DIM_W      = 13;  // signed row / col
  localparam int unsigned EXT_W      = DIM_W + 1;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned MAXD_W     = 15;
  localparam int unsigned SPREAD_W   = 8;
  localparam int unsigned COLS_W     = 12;
  localparam int unsigned ROWS_W     = 10;
  localparam int unsigned REASON_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_W       = 48;
  localparam int unsigned OUT_W      = 24;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 2'd3;

  localparam logic [MAXD_W-1:0]   MAX_DEPTH_RST = 15'd25600;
  localparam logic [SPREAD_W-1:0] SPREAD_RST    = 8'd10;
  localparam logic [COLS_W-1:0]   COLS_RST      = 12'd2048;
  localparam logic [ROWS_W-1:0]   ROWS_RST      = 10'd512;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [REASON_W-1:0] {
    RSN_OK        = 3'd0,
    RSN_OUTSIDE   = 3'd1,
    RSN_BAD_CTR   = 3'd2,
    RSN_BORDER    = 3'd3,
    RSN_NEIGHBOUR = 3'd4,
    RSN_SPREAD    = 3'd5
  } reason_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_BOUNDS = 7'b0000010,
    ST_CENTER = 7'b0000100,
    ST_WINDOW = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_SPREAD = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic take;       // input channel open
    logic bounds;     // frame check, center read issued
    logic center;     // center data present
    logic win_issue;  // issue one window read
    logic spread;     // final spread decision
    logic out_load;   // load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic query_acc;
    logic outside;
    logic center_reject;
    logic win_last;
    logic out_free;
  } status_t;

  function automatic logic depth_ok(logic signed [DEPTH_W-1:0] z,
                                    logic [MAXD_W-1:0] lim);
    logic pos;
    pos = !z[DEPTH_W-1] && (z != '0);
    return pos && (z[MAXD_W-1:0] < lim);
  endfunction

endpackage

>>> hw/rtl/kdwf_ram.sv
`timescale 1ns / 1ps

module kdwf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/kdwf_datapath.sv
`timescale 1ns / 1ps

module kdwf_datapath
  import kdwf_pkg::*;
#(
  parameter int unsigned MAX_COLS      = KDWF_MAX_COLS,
  parameter int unsigned MAX_ROWS      = KDWF_MAX_ROWS,
  parameter int unsigned WINDOW_RADIUS = KDWF_WINDOW_RADIUS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               st_o,
  input  logic                  s_axis_tvalid,
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  logic                  m_axis_tready,
  output logic                  m_axis_tvalid,
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned SPAN   = 2 * WINDOW_RADIUS;
  localparam int unsigned WIN_W  = $clog2(SPAN + 1);
  localparam int unsigned RANGE_W = DEPTH_W - 1;
  localparam int unsigned PROD_W  = SPREAD_W + RANGE_W;

  // Input fields
  logic                      in_cmd;
  logic signed [DIM_W-1:0]   in_row, in_col;
  logic [DEPTH_W-1:0]        in_depth;

  assign in_cmd   = s_axis_tdata[0];
  assign in_row   = s_axis_tdata[DIM_W:1];
  assign in_col   = s_axis_tdata[2*DIM_W:DIM_W+1];
  assign in_depth = s_axis_tdata[2*DIM_W+DEPTH_W:2*DIM_W+1];

  // Config registers
  logic [MAXD_W-1:0]   max_depth_q;
  logic [SPREAD_W-1:0] spread_q;
  logic [COLS_W-1:0]   cols_q;
  logic [ROWS_W-1:0]   rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= MAX_DEPTH_RST;
      spread_q    <= SPREAD_RST;
      cols_q      <= COLS_RST;
      rows_q      <= ROWS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_DEPTH:     max_depth_q <= cfg_data_i[MAXD_W-1:0];
        CFG_SPREAD_FACTOR: spread_q    <= cfg_data_i[SPREAD_W-1:0];
        CFG_COLS_IN_USE:   cols_q      <= cfg_data_i[COLS_W-1:0];
        CFG_ROWS_IN_USE:   rows_q      <= cfg_data_i[ROWS_W-1:0];
      endcase
    end
  end

  // Frame size saturated to [1, MAX]
  logic [EXT_W-1:0] rows_raw, cols_raw, rows_eff, cols_eff;

  assign rows_raw = EXT_W'(rows_q);
  assign cols_raw = EXT_W'(cols_q);

  always_comb begin
    if (rows_raw == '0) begin
      rows_eff = EXT_W'(1);
    end else if (rows_raw > EXT_W'(MAX_ROWS)) begin
      rows_eff = EXT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
    if (cols_raw == '0) begin
      cols_eff = EXT_W'(1);
    end else if (cols_raw > EXT_W'(MAX_COLS)) begin
      cols_eff = EXT_W'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
  end

  // Input transfer
  logic in_xfer, mem_we, wr_in_range;

  assign in_xfer     = s_axis_tvalid && cmd_i.take;
  assign wr_in_range = !in_row[DIM_W-1] && ({1'b0, in_row} < EXT_W'(MAX_ROWS)) &&
                       !in_col[DIM_W-1] && ({1'b0, in_col} < EXT_W'(MAX_COLS));
  assign mem_we      = in_xfer && (in_cmd == CMD_WRITE) && wr_in_range;

  // Query position
  logic signed [DIM_W-1:0] r_q, c_q;
  logic [EXT_W-1:0]        r_u, c_u;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      r_q <= in_row;
      c_q <= in_col;
    end
  end

  assign r_u = {1'b0, r_q};
  assign c_u = {1'b0, c_q};

  logic outside, near_border;

  assign outside     = r_q[DIM_W-1] || (r_u >= rows_eff) ||
                       c_q[DIM_W-1] || (c_u >= cols_eff);
  assign near_border = (r_u < EXT_W'(WINDOW_RADIUS)) ||
                       (r_u + EXT_W'(WINDOW_RADIUS) >= rows_eff) ||
                       (c_u < EXT_W'(WINDOW_RADIUS)) ||
                       (c_u + EXT_W'(WINDOW_RADIUS) >= cols_eff);

  // Window sweep counters
  logic [WIN_W-1:0] dr_q, dc_q;
  logic             win_last;
  logic [EXT_W-1:0] win_row, win_col;

  assign win_last = (dr_q == WIN_W'(SPAN)) && (dc_q == WIN_W'(SPAN));
  assign win_row  = r_u + EXT_W'(dr_q) - EXT_W'(WINDOW_RADIUS);
  assign win_col  = c_u + EXT_W'(dc_q) - EXT_W'(WINDOW_RADIUS);

  // Depth memory, single port
  logic [ADDR_W-1:0]  mem_addr;
  logic [DEPTH_W-1:0] mem_rdata;
  logic signed [DEPTH_W-1:0] rd_z;

  always_comb begin
    if (mem_we) begin
      mem_addr = {in_row[ROW_W-1:0], in_col[COL_W-1:0]};
    end else if (cmd_i.win_issue) begin
      mem_addr = {win_row[ROW_W-1:0], win_col[COL_W-1:0]};
    end else begin
      mem_addr = {r_q[ROW_W-1:0], c_q[COL_W-1:0]};
    end
  end

  kdwf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (1 << ADDR_W)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_depth),
    .rdata_o (mem_rdata)
  );

  assign rd_z = $signed(mem_rdata);

  logic center_bad, rd_ok;

  assign center_bad = !depth_ok(rd_z, max_depth_q);
  assign rd_ok      = depth_ok(rd_z, max_depth_q);

  // Window evaluation
  logic win_vld_q;
  logic nb_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= 1'b0;
      dr_q      <= '0;
      dc_q      <= '0;
    end else begin
      win_vld_q <= cmd_i.win_issue;
      if (cmd_i.center) begin
        dr_q <= '0;
        dc_q <= '0;
      end else if (cmd_i.win_issue) begin
        if (dc_q == WIN_W'(SPAN)) begin
          dc_q <= '0;
          dr_q <= dr_q + WIN_W'(1);
        end else begin
          dc_q <= dc_q + WIN_W'(1);
        end
      end
    end
  end

  logic signed [DEPTH_W-1:0] z_q, zmin_q, zmax_q, zrange;
  reason_e                   reason_q;
  logic [PROD_W-1:0]         prod;

  assign zrange = zmax_q - zmin_q;
  assign prod   = PROD_W'(spread_q) * PROD_W'(zrange[RANGE_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bounds && outside) begin
      z_q      <= '0;
      reason_q <= RSN_OUTSIDE;
    end
    if (cmd_i.center) begin
      z_q      <= rd_z;
      zmin_q   <= rd_z;
      zmax_q   <= rd_z;
      nb_bad_q <= 1'b0;
      if (center_bad) begin
        reason_q <= RSN_BAD_CTR;
      end else if (near_border) begin
        reason_q <= RSN_BORDER;
      end else begin
        reason_q <= RSN_OK;
      end
    end
    if (win_vld_q) begin
      if (!rd_ok) begin
        nb_bad_q <= 1'b1;
      end else begin
        if (rd_z < zmin_q) zmin_q <= rd_z;
        if (rd_z > zmax_q) zmax_q <= rd_z;
      end
    end
    if (cmd_i.spread) begin
      if (nb_bad_q) begin
        reason_q <= RSN_NEIGHBOUR;
      end else if (prod > PROD_W'(z_q[RANGE_W-1:0])) begin
        reason_q <= RSN_SPREAD;
      end else begin
        reason_q <= RSN_OK;
      end
    end
  end

  // Result register
  logic                m_valid_q;
  logic                out_acc_q;
  reason_e             out_reason_q;
  logic [DEPTH_W-1:0]  out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q    <= (reason_q == RSN_OK);
      out_reason_q <= reason_q;
      out_z_q      <= z_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_W - 1 - REASON_W - DEPTH_W)'(0), out_z_q, out_reason_q, out_acc_q};

  assign st_o.query_acc     = in_xfer && (in_cmd == CMD_QUERY);
  assign st_o.outside       = outside;
  assign st_o.center_reject = center_bad || near_border;
  assign st_o.win_last      = win_last;
  assign st_o.out_free      = !m_valid_q || m_axis_tready;

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> cmd_i.take)
    else $error("depth write while a query is in progress");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result overwritten before transfer");

  a_ok_valid_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && reason_q == RSN_OK) |-> depth_ok(z_q, max_depth_q))
    else $error("accepted keypoint with invalid center depth");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.bounds && outside) |=> (reason_q == RSN_OUTSIDE && z_q == '0))
    else $error("outside query result not set");

endmodule

>>> hw/rtl/kdwf_ctrl.sv
`timescale 1ns / 1ps

module kdwf_ctrl
  import kdwf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (st_i.query_acc) state_d = ST_BOUNDS;
      end
      ST_BOUNDS: begin
        cmd_o.bounds = 1'b1;
        state_d = st_i.outside ? ST_RESULT : ST_CENTER;
      end
      ST_CENTER: begin
        cmd_o.center = 1'b1;
        state_d = st_i.center_reject ? ST_RESULT : ST_WINDOW;
      end
      ST_WINDOW: begin
        cmd_o.win_issue = 1'b1;
        if (st_i.win_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_SPREAD;
      end
      ST_SPREAD: begin
        cmd_o.spread = 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_window_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WINDOW && st_i.win_last) |=> state_q == ST_DRAIN)
    else $error("window sweep did not end after last read");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && st_i.query_acc) |=> state_q == ST_BOUNDS)
    else $error("accepted query not started");

endmodule

>>> hw/rtl/keypoint_depth_window_filter.sv
`timescale 1ns / 1ps
// A depth write within MAX_ROWS by MAX_COLS is stored at its transfer and gives no result.
// A query outside the frame goes from the bounds check to the result, and one that the center
// or border check rejects from the center check; else a window sweep of one read per cycle on
// the single-port depth memory, a drain and the spread decision come first. One write per cycle
// is taken while idle; no new query or write is taken until the query's result is loaded.
// Reset: config registers take their defaults; depth memory is not cleared.

module keypoint_depth_window_filter
  import kdwf_pkg::*;
#(
  parameter int unsigned MAX_COLS      = KDWF_MAX_COLS,
  parameter int unsigned MAX_ROWS      = KDWF_MAX_ROWS,
  parameter int unsigned WINDOW_RADIUS = KDWF_WINDOW_RADIUS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // command[0], row[13:1], col[26:14], depth[42:27], zero pad above
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // accepted[0], reason[3:1], center_depth[19:4], zero pad above
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  kdwf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  kdwf_datapath #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .WINDOW_RADIUS (WINDOW_RADIUS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  assign s_axis_tready = cmd.take;
  assign cfg_ready_o   = 1'b1;

endmodule
